/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers. They compile to nothing under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Assertion on an explicit clock and active-low reset.
`define ZCPE_ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("zcpe assertion failed");
// Assertion on the block clock and reset.
`define ZCPE_ASSERT(lbl, prop) `ZCPE_ASSERT_CLK(lbl, clk_i, rst_ni, prop)
`else
`define ZCPE_ASSERT_CLK(lbl, clk, rst_n, prop)
`define ZCPE_ASSERT(lbl, prop)
`endif
`endif

/* rtl/zcpe_pkg.sv */
// ----------------------------------------------------------------------------
// zcpe_pkg
// Types, constants and register indexes of the zero-crossing pulse encoder.
// ----------------------------------------------------------------------------
package zcpe_pkg;

  // Width of the elapsed microsecond counter and of the divider dividend.
  localparam int ELAPSED_BITS = 32;
  localparam int CNT_W        = $clog2(ELAPSED_BITS);

  // Field and register widths.
  localparam int SAMPLE_W = 16;
  localparam int RATE_W   = 18;
  localparam int UNIT_W   = 10;
  localparam int CFG_W    = RATE_W;
  localparam int CFG_IDX_W = 2;
  localparam int BAL_W    = 21;
  localparam int TICK_W   = 20;
  localparam int HALF_W   = 16;
  localparam int LEN_W    = 7;
  localparam int LEVEL_W  = 8;
  localparam int DIV_W    = RATE_W;

  // Time balance gain per sample.
  localparam logic [BAL_W-1:0] TICKS_PER_SAMPLE = BAL_W'(1000000);

  // Register reset values.
  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(44100);
  localparam logic [UNIT_W-1:0] UNIT_RESET = UNIT_W'(9);

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PLAYBACK_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_US_PER_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STANDARD_MODE = 2'd2;

  // Pulse length codes and limits.
  localparam logic [LEN_W-1:0] LEN_SHORT = 7'h20;
  localparam logic [LEN_W-1:0] LEN_LONG  = 7'h30;
  localparam logic [LEN_W-1:0] LEN_MAX   = 7'h7f;
  localparam logic [LEN_W-1:0] LEN_MIN   = 7'h01;

  // The short code is chosen while (48 * n) / 18 < 0x28, which holds exactly
  // while 8 * n < 120, that is for fewer than 15 samples.
  localparam logic [HALF_W-1:0] STD_SAMPLE_LIMIT = HALF_W'(15);

  // Level bytes.
  localparam logic [LEVEL_W-1:0] LEVEL_POS = 8'h00;
  localparam logic [LEVEL_W-1:0] LEVEL_NEG = 8'h80;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TIME,
    ST_DECIDE,
    ST_LEN,
    ST_EMIT
  } state_e;

  // Configuration register contents.
  typedef struct packed {
    logic [RATE_W-1:0] playback_rate;
    logic [UNIT_W-1:0] us_per_count;
    logic              standard_mode;
  } cfg_t;

  // Divider request and response.
  typedef struct packed {
    logic                    start;
    logic [ELAPSED_BITS-1:0] dividend;
    logic [DIV_W-1:0]        divisor;
  } div_req_t;

  typedef struct packed {
    logic                    busy;
    logic                    done;
    logic [ELAPSED_BITS-1:0] quotient;
    logic [DIV_W-1:0]        remainder;
  } div_rsp_t;

endpackage

/* rtl/zcpe_regs.sv */
// ----------------------------------------------------------------------------
// zcpe_regs
// Configuration registers, written through a plain index and data port.
// ----------------------------------------------------------------------------
module zcpe_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [zcpe_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [zcpe_pkg::CFG_W-1:0]      cfg_data_i,
  output zcpe_pkg::cfg_t                  cfg_o
);

  zcpe_pkg::cfg_t cfg_q;

  // Register write; unknown indexes are dropped and upper data bits ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.playback_rate <= zcpe_pkg::RATE_RESET;
      cfg_q.us_per_count  <= zcpe_pkg::UNIT_RESET;
      cfg_q.standard_mode <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        zcpe_pkg::CFG_PLAYBACK_RATE: begin
          cfg_q.playback_rate <= cfg_data_i[zcpe_pkg::RATE_W-1:0];
        end
        zcpe_pkg::CFG_US_PER_COUNT: begin
          cfg_q.us_per_count <= cfg_data_i[zcpe_pkg::UNIT_W-1:0];
        end
        zcpe_pkg::CFG_STANDARD_MODE: begin
          cfg_q.standard_mode <= cfg_data_i[0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/zcpe_div.sv */
// ----------------------------------------------------------------------------
// zcpe_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module zcpe_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  zcpe_pkg::div_req_t  req_i,
  output zcpe_pkg::div_rsp_t  rsp_o
);

  localparam int EB = zcpe_pkg::ELAPSED_BITS;
  localparam int DW = zcpe_pkg::DIV_W;

  logic                         busy_q;
  logic                         done_q;
  logic [zcpe_pkg::CNT_W-1:0]   cnt_q;
  logic [EB-1:0]                quo_q;
  logic [DW-1:0]                rem_q;
  logic [DW-1:0]                dvs_q;

  logic [DW:0]                  shifted;
  logic [DW:0]                  diff;
  logic                         ge;
  logic                         last;

  // One step: bring in the next dividend bit and try a subtraction.
  always_comb begin
    shifted = {rem_q, quo_q[EB-1]};
    ge      = (shifted >= {1'b0, dvs_q});
    diff    = shifted - {1'b0, dvs_q};
    last    = (cnt_q == zcpe_pkg::CNT_W'(EB - 1));
  end

  // Control: busy while the dividend bits are worked through, then a done pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Datapath: quotient bits shift in where dividend bits shift out.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[EB-2:0], ge};
      rem_q <= ge ? diff[DW-1:0] : shifted[DW-1:0];
    end
  end

  assign rsp_o.busy      = busy_q;
  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

/* rtl/zero_crossing_pulse_encoder.sv */
// ----------------------------------------------------------------------------
// zero_crossing_pulse_encoder
// Turns signed audio samples into half-wave pulse records. Each accepted
// sample advances a microsecond clock kept by a time balance; every polarity
// flip emits one beat with the level of the ended half-wave and its length,
// either a fixed code in standard mode or elapsed microseconds per count unit.
// A sample runs through ST_TIME and ST_DECIDE; one that ends a standard-mode
// half-wave then passes ST_EMIT, and one that ends a timed half-wave passes
// ST_LEN and then ST_EMIT, which waits for the output register to empty.
// The single shared divider retires one quotient bit per cycle and is used
// once for the microsecond count and once more for the pulse length. The
// input is not ready while a sample is in work; a finished beat waits in the
// output register without holding off the next sample.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module zero_crossing_pulse_encoder (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [zcpe_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [zcpe_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [zcpe_pkg::SAMPLE_W-1:0] sample_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [zcpe_pkg::LEVEL_W-1:0]      level_byte_o,
  output logic [zcpe_pkg::LEN_W-1:0]        pulse_length_o
);

  localparam int EB = zcpe_pkg::ELAPSED_BITS;
  localparam int DW = zcpe_pkg::DIV_W;
  localparam int BW = zcpe_pkg::BAL_W;

  zcpe_pkg::cfg_t     cfg;
  zcpe_pkg::div_req_t div_req;
  zcpe_pkg::div_rsp_t div_rsp;

  zcpe_pkg::state_e   state_q, state_d;

  logic signed [zcpe_pkg::SAMPLE_W-1:0] sample_q;
  logic signed [BW-1:0]                 balance_q, balance_d;
  logic [EB-1:0]                        elapsed_q, elapsed_d;
  logic [zcpe_pkg::HALF_W-1:0]          half_q, half_d;
  logic                                 pol_q, pol_d;
  logic                                 seen_q, seen_d;
  logic [zcpe_pkg::LEN_W-1:0]           len_q, len_d;

  logic                                 out_valid_q, out_valid_d;
  logic [zcpe_pkg::LEVEL_W-1:0]         level_q;
  logic [zcpe_pkg::LEN_W-1:0]           plen_q;
  logic                                 out_load;

  logic                                 accept;
  logic [zcpe_pkg::RATE_W-1:0]          rate_eff;
  logic [zcpe_pkg::UNIT_W-1:0]          unit_eff;
  logic signed [BW-1:0]                 bal_gain;
  logic                                 rem_nz;
  logic [EB-1:0]                        n_us;
  logic [EB:0]                          elapsed_sum;
  logic                                 skip;
  logic                                 flip;
  logic                                 len_hi;
  logic                                 out_free;

  // Configuration registers.
  zcpe_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Shared divider.
  zcpe_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Datapath terms shared by the sequencer blocks.
  always_comb begin
    accept   = in_valid_i && in_ready_o;
    rate_eff = (cfg.playback_rate == '0) ? zcpe_pkg::RATE_W'(1) : cfg.playback_rate;
    unit_eff = (cfg.us_per_count == '0) ? zcpe_pkg::UNIT_W'(1) : cfg.us_per_count;
    // The balance lies in (-rate, 0], so the sum is positive and below 2^20.
    bal_gain = balance_q + $signed(zcpe_pkg::TICKS_PER_SAMPLE);
    // Ceiling division: one more microsecond when the remainder is nonzero.
    rem_nz      = (div_rsp.remainder != '0);
    n_us        = div_rsp.quotient + EB'(rem_nz);
    elapsed_sum = {1'b0, elapsed_q} + {1'b0, n_us};
    skip        = !seen_q && (sample_q == '0);
    flip        = (!pol_q && !sample_q[zcpe_pkg::SAMPLE_W-1] && (sample_q != '0))
               || (pol_q && sample_q[zcpe_pkg::SAMPLE_W-1]);
    len_hi      = |div_rsp.quotient[EB-1:zcpe_pkg::LEN_W];
    out_free    = !out_valid_q || out_ready_i;
  end

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      zcpe_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = zcpe_pkg::ST_TIME;
        end
      end
      zcpe_pkg::ST_TIME: begin
        if (div_rsp.done) begin
          state_d = zcpe_pkg::ST_DECIDE;
        end
      end
      zcpe_pkg::ST_DECIDE: begin
        if (skip || !flip) begin
          state_d = zcpe_pkg::ST_IDLE;
        end else if (cfg.standard_mode) begin
          state_d = zcpe_pkg::ST_EMIT;
        end else begin
          state_d = zcpe_pkg::ST_LEN;
        end
      end
      zcpe_pkg::ST_LEN: begin
        if (div_rsp.done) begin
          state_d = zcpe_pkg::ST_EMIT;
        end
      end
      zcpe_pkg::ST_EMIT: begin
        if (out_free) begin
          state_d = zcpe_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = zcpe_pkg::ST_IDLE;
      end
    endcase
  end

  // Output and datapath control of the sequencer.
  always_comb begin
    in_ready_o       = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = EB'(bal_gain[zcpe_pkg::TICK_W-1:0]);
    div_req.divisor  = rate_eff;
    balance_d        = balance_q;
    elapsed_d        = elapsed_q;
    half_d           = half_q;
    pol_d            = pol_q;
    seen_d           = seen_q;
    len_d            = len_q;
    out_load         = 1'b0;
    unique case (state_q)
      zcpe_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        div_req.start = in_valid_i;
      end
      zcpe_pkg::ST_TIME: begin
        // Take ceil(b / rate) microseconds and keep what is left in the balance.
        if (div_rsp.done) begin
          balance_d = rem_nz
                    ? ($signed(BW'(div_rsp.remainder)) - $signed(BW'(rate_eff)))
                    : '0;
          elapsed_d = elapsed_sum[EB] ? {EB{1'b1}} : elapsed_sum[EB-1:0];
        end
      end
      zcpe_pkg::ST_DECIDE: begin
        if (!skip) begin
          seen_d = 1'b1;
          if (!flip) begin
            if (half_q != {zcpe_pkg::HALF_W{1'b1}}) begin
              half_d = half_q + 1'b1;
            end
          end else if (cfg.standard_mode) begin
            len_d = (half_q < zcpe_pkg::STD_SAMPLE_LIMIT)
                  ? zcpe_pkg::LEN_SHORT : zcpe_pkg::LEN_LONG;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = elapsed_q;
            div_req.divisor  = DW'(unit_eff);
          end
        end
      end
      zcpe_pkg::ST_LEN: begin
        // Whole count units become the length, clamped to LEN_MIN..LEN_MAX; the remainder carries over.
        if (div_rsp.done) begin
          elapsed_d = EB'(div_rsp.remainder);
          if (div_rsp.quotient == '0) begin
            len_d = zcpe_pkg::LEN_MIN;
          end else if (len_hi) begin
            len_d = zcpe_pkg::LEN_MAX;
          end else begin
            len_d = div_rsp.quotient[zcpe_pkg::LEN_W-1:0];
          end
        end
      end
      zcpe_pkg::ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          half_d   = '0;
          pol_d    = !pol_q;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register valid.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  // Control and state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= zcpe_pkg::ST_IDLE;
      balance_q   <= '0;
      elapsed_q   <= '0;
      half_q      <= '0;
      pol_q       <= 1'b0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      balance_q   <= balance_d;
      elapsed_q   <= elapsed_d;
      half_q      <= half_d;
      pol_q       <= pol_d;
      seen_q      <= seen_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q <= sample_i;
    end
    len_q <= len_d;
    if (out_load) begin
      level_q <= pol_q ? zcpe_pkg::LEVEL_POS : zcpe_pkg::LEVEL_NEG;
      plen_q  <= len_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign level_byte_o   = level_q;
  assign pulse_length_o = plen_q;

  // The input is only taken while the divider is free.
  `ZCPE_ASSERT(a_ready_div_idle, in_ready_o |-> !div_rsp.busy)
  // The time balance never goes positive between samples.
  `ZCPE_ASSERT(a_balance_nonpos, (state_q == zcpe_pkg::ST_IDLE) |-> (balance_q <= 0))
  // A divider result only follows a running division.
  `ZCPE_ASSERT(a_done_after_busy, div_rsp.done |-> $past(div_rsp.busy))
  // A beat never carries a zero length.
  `ZCPE_ASSERT(a_len_nonzero, out_valid_o |-> (pulse_length_o != '0))

endmodule
